// ===== rtl/core/slt_pkg.sv =====
// slt_pkg: shared types, character and kind codes, and the lexer step functions
// used by the tokenizer front end, token queue and back end. no dependencies.
`default_nettype none

package slt_pkg;

  // scanner modes
  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_WS     = 4'd1;
  localparam logic [3:0] M_ID     = 4'd2;
  localparam logic [3:0] M_LT     = 4'd3;
  localparam logic [3:0] M_GT     = 4'd4;
  localparam logic [3:0] M_INT    = 4'd5;
  localparam logic [3:0] M_INTDOT = 4'd6;
  localparam logic [3:0] M_FRAC   = 4'd7;
  localparam logic [3:0] M_E_I    = 4'd8;
  localparam logic [3:0] M_ES_I   = 4'd9;
  localparam logic [3:0] M_E_R    = 4'd10;
  localparam logic [3:0] M_ES_R   = 4'd11;
  localparam logic [3:0] M_EXP    = 4'd12;

  // token kinds
  localparam logic [4:0] K_END     = 5'd0;
  localparam logic [4:0] K_WS      = 5'd1;
  localparam logic [4:0] K_ID      = 5'd2;
  localparam logic [4:0] K_IF      = 5'd3;
  localparam logic [4:0] K_ELSE    = 5'd4;
  localparam logic [4:0] K_INT     = 5'd5;
  localparam logic [4:0] K_REAL    = 5'd6;
  localparam logic [4:0] K_SCI     = 5'd7;
  localparam logic [4:0] K_EQ      = 5'd8;
  localparam logic [4:0] K_NE      = 5'd9;
  localparam logic [4:0] K_LT      = 5'd10;
  localparam logic [4:0] K_LE      = 5'd11;
  localparam logic [4:0] K_GT      = 5'd12;
  localparam logic [4:0] K_GE      = 5'd13;
  localparam logic [4:0] K_QUOTE   = 5'd14;
  localparam logic [4:0] K_LPAREN  = 5'd15;
  localparam logic [4:0] K_RPAREN  = 5'd16;
  localparam logic [4:0] K_LBRACE  = 5'd17;
  localparam logic [4:0] K_RBRACE  = 5'd18;
  localparam logic [4:0] K_LBRACK  = 5'd19;
  localparam logic [4:0] K_RBRACK  = 5'd20;
  localparam logic [4:0] K_COMMA   = 5'd21;
  localparam logic [4:0] K_SEMI    = 5'd22;
  localparam logic [4:0] K_PLUS    = 5'd23;
  localparam logic [4:0] K_MINUS   = 5'd24;
  localparam logic [4:0] K_STAR    = 5'd25;
  localparam logic [4:0] K_SLASH   = 5'd26;
  localparam logic [4:0] K_DOT     = 5'd27;
  localparam logic [4:0] K_UNKNOWN = 5'd28;

  // keyword match progress
  localparam logic [2:0] KP_NONE = 3'd0;
  localparam logic [2:0] KP_I    = 3'd1;
  localparam logic [2:0] KP_IF   = 3'd2;
  localparam logic [2:0] KP_E    = 3'd3;
  localparam logic [2:0] KP_EL   = 3'd4;
  localparam logic [2:0] KP_ELS  = 3'd5;
  localparam logic [2:0] KP_ELSE = 3'd6;

  // characters
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [15:0] len;
    logic [23:0] line;
    logic [7:0]  first;
  } token_t;

  // all tokens closed by one input word
  typedef struct packed {
    logic [2:0]        cnt;
    token_t [3:0]      tok;
  } bundle_t;

  typedef struct packed {
    logic [3:0]       mode;
    logic [31:0]      start;
    logic [31:0]      len;
    logic [23:0]      line;
    logic [7:0]       first;
    logic [2:0]       kp;
    logic             sep;
    logic [1:0]       hcnt;
    logic [1:0][7:0]  held;
  } lex_state_t;

  typedef struct packed {
    lex_state_t st;
    bundle_t    b;
    logic       rew;
  } ctx_t;

  localparam lex_state_t LEX_RESET = '{
    mode: M_IDLE, start: 32'd0, len: 32'd0, line: 24'd1, first: 8'd0,
    kp: KP_NONE, sep: 1'b0, hcnt: 2'd0, held: '0};

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] len, logic [1:0] n,
                                          logic [31:0] lmax);
    logic [32:0] s;
    s = {1'b0, len} + {31'd0, n};
    if (s > {1'b0, lmax}) s = {1'b0, lmax};
    return s[31:0];
  endfunction

  function automatic bundle_t push(bundle_t b, logic [4:0] k, logic [31:0] start,
                                   logic [31:0] len, logic [23:0] line,
                                   logic [7:0] first);
    bundle_t r;
    r = b;
    if (b.cnt < 3'd4) begin
      r.tok[b.cnt[1:0]] = '{kind: k, start: start, len: len[15:0], line: line,
                            first: first};
      r.cnt = b.cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic logic [4:0] single_kind(logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      CH_EQ:     k = K_EQ;
      CH_QUOTE:  k = K_QUOTE;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_LBRACK: k = K_LBRACK;
      CH_RBRACK: k = K_RBRACK;
      CH_COMMA:  k = K_COMMA;
      CH_SEMI:   k = K_SEMI;
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_STAR;
      CH_SLASH:  k = K_SLASH;
      CH_DOT:    k = K_DOT;
      default:   k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] kw_next(logic [2:0] kp, logic [7:0] c);
    logic [2:0] r;
    r = KP_NONE;
    if (kp == KP_I && c == CH_F) r = KP_IF;
    if (kp == KP_E && c == CH_L) r = KP_EL;
    if (kp == KP_EL && c == CH_S) r = KP_ELS;
    if (kp == KP_ELS && c == CH_E) r = KP_ELSE;
    return r;
  endfunction

  function automatic logic [4:0] number_kind(logic [3:0] m);
    logic [4:0] k;
    k = K_INT;
    if (m == M_FRAC || m == M_E_R || m == M_ES_R) k = K_REAL;
    if (m == M_EXP) k = K_SCI;
    return k;
  endfunction

  function automatic lex_state_t commit(lex_state_t s, logic [3:0] nxt,
                                        logic [31:0] lmax);
    lex_state_t r;
    r = s;
    r.len  = sat_add(s.len, s.hcnt + 2'd1, lmax);
    r.hcnt = 2'd0;
    r.sep  = 1'b0;
    r.mode = nxt;
    return r;
  endfunction

  function automatic lex_state_t hold(lex_state_t s, logic [7:0] c);
    lex_state_t r;
    r = s;
    if (s.hcnt < 2'd2) begin
      r.held[s.hcnt[0]] = c;
      r.hcnt = s.hcnt + 2'd1;
    end
    return r;
  endfunction

  function automatic lex_state_t open_tok(lex_state_t s, logic [7:0] c,
                                          logic [31:0] off, logic [23:0] line,
                                          logic [3:0] mode, logic [31:0] lmax);
    lex_state_t r;
    r = s;
    r.mode  = mode;
    r.start = off;
    r.line  = line;
    r.first = c;
    r.len   = sat_add(32'd0, 2'd1, lmax);
    r.sep   = 1'b0;
    r.hcnt  = 2'd0;
    r.kp    = KP_NONE;
    return r;
  endfunction

  // first character of a token, scanner idle
  function automatic ctx_t start_tok(ctx_t ci, logic [7:0] c, logic e,
                                     logic [31:0] off, logic [23:0] line,
                                     logic [31:0] lmax);
    ctx_t r;
    r = ci;
    if (e) begin
      r.b = push(r.b, K_END, off, 32'd0, line, 8'd0);
    end else if (is_space(c)) begin
      r.st = open_tok(r.st, c, off, line, M_WS, lmax);
    end else if (is_alpha(c)) begin
      r.st = open_tok(r.st, c, off, line, M_ID, lmax);
      r.st.kp = (c == CH_I) ? KP_I : (c == CH_E) ? KP_E : KP_NONE;
    end else if (is_digit(c)) begin
      r.st = open_tok(r.st, c, off, line, M_INT, lmax);
    end else if (c == CH_LT) begin
      r.st = open_tok(r.st, c, off, line, M_LT, lmax);
    end else if (c == CH_GT) begin
      r.st = open_tok(r.st, c, off, line, M_GT, lmax);
    end else begin
      r.b = push(r.b, single_kind(c), off, 32'd1, line, c);
    end
    return r;
  endfunction

  // one character through the scanner; rew asks the caller to relex held bytes
  function automatic ctx_t lex_char(ctx_t ci, logic [7:0] c, logic e,
                                    logic [31:0] off, logic [23:0] line,
                                    logic [31:0] lmax);
    ctx_t       r;
    logic       term;
    logic       dig;
    logic       ok;
    logic [3:0] m;
    logic [4:0] k;
    r    = ci;
    r.rew = 1'b0;
    term = 1'b0;
    m    = ci.st.mode;
    dig  = !e && is_digit(c);
    ok   = !e && !ci.st.sep;
    k    = K_ID;
    unique case (m)
      M_IDLE: begin
        r = start_tok(r, c, e, off, line, lmax);
      end
      M_WS: begin
        if (!e && is_space(c)) begin
          r.st.len = sat_add(r.st.len, 2'd1, lmax);
        end else begin
          r.b = push(r.b, K_WS, r.st.start, r.st.len, r.st.line, r.st.first);
          term = 1'b1;
        end
      end
      M_ID: begin
        if (!e && (is_alpha(c) || is_digit(c))) begin
          r.st.len = sat_add(r.st.len, 2'd1, lmax);
          r.st.kp  = kw_next(r.st.kp, c);
        end else begin
          if (r.st.kp == KP_IF) k = K_IF;
          if (r.st.kp == KP_ELSE) k = K_ELSE;
          r.b = push(r.b, k, r.st.start, r.st.len, r.st.line, r.st.first);
          term = 1'b1;
        end
      end
      M_LT, M_GT: begin
        if (!e && (c == CH_EQ || (m == M_LT && c == CH_GT))) begin
          r.st.len = sat_add(r.st.len, 2'd1, lmax);
          k = (m == M_GT) ? K_GE : (c == CH_EQ) ? K_LE : K_NE;
          r.b = push(r.b, k, r.st.start, r.st.len, r.st.line, r.st.first);
          r.st.mode = M_IDLE;
        end else begin
          k = (m == M_LT) ? K_LT : K_GT;
          r.b = push(r.b, k, r.st.start, r.st.len, r.st.line, r.st.first);
          term = 1'b1;
        end
      end
      M_INT, M_FRAC, M_EXP: begin
        if (dig) begin
          r.st = commit(r.st, m, lmax);
        end else if (ok && c == CH_QUOTE) begin
          r.st = hold(r.st, c);
          r.st.sep = 1'b1;
        end else if (ok && c == CH_DOT && m == M_INT) begin
          r.st = hold(r.st, c);
          r.st.mode = M_INTDOT;
        end else if (ok && (c == CH_E || c == CH_UPPER_E) && m != M_EXP) begin
          r.st = hold(r.st, c);
          r.st.mode = (m == M_INT) ? M_E_I : M_E_R;
        end else begin
          r.rew = 1'b1;
        end
      end
      M_INTDOT, M_E_I, M_E_R: begin
        if (dig) begin
          r.st = commit(r.st, (m == M_INTDOT) ? M_FRAC : M_EXP, lmax);
        end else if (!e && m != M_INTDOT && (c == CH_PLUS || c == CH_MINUS)) begin
          r.st = hold(r.st, c);
          r.st.mode = (m == M_E_I) ? M_ES_I : M_ES_R;
        end else begin
          r.rew = 1'b1;
        end
      end
      M_ES_I, M_ES_R: begin
        if (dig) r.st = commit(r.st, M_EXP, lmax);
        else r.rew = 1'b1;
      end
      default: begin
        r.st.hcnt = 2'd0;
        term = 1'b1;
      end
    endcase
    // close the number; held bytes stay for the caller
    if (r.rew) begin
      r.b = push(r.b, number_kind(m), r.st.start, r.st.len, r.st.line, r.st.first);
    end
    if (term) begin
      r.st.mode = M_IDLE;
      r = start_tok(r, c, e, off, line, lmax);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/slt_stream_if.sv =====
// slt_stream_if: source byte channel and token channel of the tokenizer.
// no dependencies.
`default_nettype none

interface slt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_end;
  modport source (output valid, ch, is_end, input ready);
  modport sink (input valid, ch, is_end, output ready);
endinterface

interface slt_tok_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [31:0] start_offset;
  logic [15:0] length;
  logic [23:0] start_line;
  logic [7:0]  first_char;
  logic        last;
  modport source (output valid, kind, start_offset, length, start_line, first_char,
                  last, input ready);
  modport sink (input valid, kind, start_offset, length, start_line, first_char,
                last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/small_language_tokenizer.sv =====
// small_language_tokenizer: streaming lexer, one source byte per cycle.
// a token is offered once its bundle has passed the queue and is loaded in the back end.
// throughput: 1 byte per cycle while the queue is not full; a byte closing k tokens
// has them sent one per cycle while tok_o is ready, behind a two-bundle queue.
// reset: asynchronous, active low; stream restarts at offset 0, line 1, queue empty.
// depends on slt_pkg, slt_stream_if, slt_front, slt_queue, slt_back.
`default_nettype none

module small_language_tokenizer #(
  parameter int unsigned LENGTH_MAX = 65535
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  slt_in_if.sink      in_i,
  slt_tok_if.source   tok_o
);
  import slt_pkg::*;

  bundle_t fb_data;
  logic    fb_valid;
  logic    q_full;
  bundle_t qb_data;
  logic    qb_valid;
  logic    qb_pop;

  // front end: scanner
  slt_front #(.LENGTH_MAX(LENGTH_MAX)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .bnd_o       (fb_data),
    .bnd_valid_o (fb_valid),
    .bnd_ready_i (!q_full)
  );

  // bundle queue
  slt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fb_valid),
    .data_i  (fb_data),
    .full_o  (q_full),
    .pop_i   (qb_pop),
    .data_o  (qb_data),
    .valid_o (qb_valid)
  );

  // back end: token serializer
  slt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_data_i  (qb_data),
    .q_valid_i (qb_valid),
    .pop_o     (qb_pop),
    .tok_o     (tok_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/slt_front.sv =====
// slt_front: accepts source bytes, runs the scanner dfa including the
// relex of held bytes, and hands each word's token bundle on. uses slt_pkg.
`default_nettype none

module slt_front #(
  parameter int unsigned LENGTH_MAX = 65535
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  slt_in_if.sink             in_i,
  output slt_pkg::bundle_t   bnd_o,
  output logic               bnd_valid_o,
  input  wire                bnd_ready_i
);
  import slt_pkg::*;

  localparam logic [31:0] LMAX = 32'(LENGTH_MAX);

  lex_state_t      st_q, st_d;
  logic [23:0]     line_q, line_d;
  logic [31:0]     off_q, off_d;
  ctx_t            a;
  logic [1:0]      n;
  logic [1:0][7:0] h;
  logic            fire;

  assign in_i.ready = bnd_ready_i;
  assign fire       = in_i.valid && bnd_ready_i;

  // scan one word, relex held bytes after a backtrack
  always_comb begin
    a     = '0;
    a.st  = st_q;
    a     = lex_char(a, in_i.ch, in_i.is_end, off_q, line_q, LMAX);
    n     = a.st.hcnt;
    h     = a.st.held;
    if (a.rew) begin
      a.st.mode = M_IDLE;
      a.st.hcnt = 2'd0;
      a.st.sep  = 1'b0;
      a.rew     = 1'b0;
      if (n != 2'd0) a = lex_char(a, h[0], 1'b0, off_q - {30'd0, n}, line_q, LMAX);
      if (n == 2'd2) a = lex_char(a, h[1], 1'b0, off_q - 32'd1, line_q, LMAX);
      a = lex_char(a, in_i.ch, in_i.is_end, off_q, line_q, LMAX);
    end
  end

  // stream position and next scanner state
  always_comb begin
    if (in_i.is_end) begin
      st_d   = LEX_RESET;
      line_d = 24'd1;
      off_d  = 32'd0;
    end else begin
      st_d   = a.st;
      line_d = (in_i.ch == CH_NL && line_q < LINE_MAX) ? line_q + 24'd1 : line_q;
      off_d  = off_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= LEX_RESET;
      line_q <= 24'd1;
      off_q  <= 32'd0;
    end else if (fire) begin
      st_q   <= st_d;
      line_q <= line_d;
      off_q  <= off_d;
    end
  end

  assign bnd_o       = a.b;
  assign bnd_valid_o = fire && (a.b.cnt != 3'd0);

endmodule

`default_nettype wire

// ===== rtl/core/slt_queue.sv =====
// slt_queue: two-entry queue of token bundles between front and back end.
// uses slt_pkg.
`default_nettype none

module slt_queue (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  slt_pkg::bundle_t  data_i,
  output logic              full_o,
  input  wire               pop_i,
  output slt_pkg::bundle_t  data_o,
  output logic              valid_o
);
  import slt_pkg::*;

  bundle_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // bundle storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push_i || pop_i)
    else $error("bundle pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0)
    else $error("bundle popped from empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/slt_back.sv =====
// slt_back: takes token bundles from the queue and delivers their tokens
// one word per cycle while tok_o is ready, flagging the last of each bundle. uses slt_pkg.
`default_nettype none

module slt_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  slt_pkg::bundle_t  q_data_i,
  input  wire               q_valid_i,
  output logic              pop_o,
  slt_tok_if.source         tok_o
);
  import slt_pkg::*;

  bundle_t    cur_q;
  logic [1:0] idx_q;
  logic       busy_q;
  token_t     tok;
  logic       last;
  logic       fire;
  logic       done;
  logic       load;

  assign tok  = cur_q.tok[idx_q];
  assign last = ({1'b0, idx_q} + 3'd1) == cur_q.cnt;
  assign fire = busy_q && tok_o.ready;
  assign done = fire && last;
  assign load = q_valid_i && (!busy_q || done);
  assign pop_o = load;

  // output word
  assign tok_o.valid        = busy_q;
  assign tok_o.kind         = tok.kind;
  assign tok_o.start_offset = tok.start;
  assign tok_o.length       = tok.len;
  assign tok_o.start_line   = tok.line;
  assign tok_o.first_char   = tok.first;
  assign tok_o.last         = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      if (load) busy_q <= 1'b1;
      else if (done) busy_q <= 1'b0;
      if (load) idx_q <= 2'd0;
      else if (fire) idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= q_data_i;
  end

`ifndef NO_ASSERTIONS
  a_bundle_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cur_q.cnt != 3'd0 && cur_q.cnt <= 3'd4)
    else $error("empty or oversized bundle in back end");
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> {1'b0, idx_q} < cur_q.cnt)
    else $error("token index past end of bundle");
`endif

endmodule

`default_nettype wire
